[hw/rtl/block_density_binarizer_unit_macros.svh]
// Assertion macros used by the block density binarizer back end.
`ifndef BLOCK_DENSITY_BINARIZER_UNIT_MACROS_SVH
`define BLOCK_DENSITY_BINARIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBIN_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBIN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dbin_pkg.sv]
// Package with shared types and constants of the block density binarizer.
`timescale 1ns / 1ps

package dbin_pkg;

	// fixed field widths of the result item
	localparam int BLOCK_IDX_W = 11;
	localparam int COUNT_OUT_W = 11;
	localparam int COLOR_W     = 8;

	localparam logic [COLOR_W-1:0] COLOR_SET   = 8'd255;
	localparam logic [COLOR_W-1:0] COLOR_CLEAR = 8'd0;

	// only this bit of a mask pixel is counted
	localparam logic [7:0] PIXEL_SET_MASK = 8'h01;

	// configuration register indexes
	localparam logic [1:0] REG_LOG2_BLOCK = 2'd0;
	localparam logic [1:0] REG_THRESHOLD  = 2'd1;
	localparam logic [1:0] REG_WIDTH      = 2'd2;
	localparam logic [1:0] REG_HEIGHT     = 2'd3;

	// configuration reset values
	localparam logic [2:0]  RST_LOG2_BLOCK = 3'd3;
	localparam logic [10:0] RST_THRESHOLD  = 11'd0;
	localparam logic [11:0] RST_WIDTH      = 12'd640;
	localparam logic [11:0] RST_HEIGHT     = 12'd480;

	// queue depths (powers of two)
	localparam int CQ_DEPTH = 4;
	localparam int RQ_DEPTH = 4;

	typedef struct packed {
		logic [BLOCK_IDX_W-1:0] block_row;
		logic [BLOCK_IDX_W-1:0] block_col;
		logic [COLOR_W-1:0]     block_color;
		logic [COUNT_OUT_W-1:0] set_count;
	} dbin_result_t;

endpackage

[hw/rtl/dbin_ram.sv]
// Generic single-write, single-read RAM with registered read (old data on collision).
`timescale 1ns / 1ps

module dbin_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/dbin_fifo.sv]
// Small register-based queue with fill level.
`timescale 1ns / 1ps

module dbin_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (level_q == '0);
	assign full  = (level_q == LVL_W'(DEPTH));
	assign level = level_q;

endmodule

[hw/rtl/dbin_front.sv]
// Front end: tracks raster position and classifies each pixel against the block grid.
`timescale 1ns / 1ps

module dbin_front import dbin_pkg::*; #(
	parameter int MAX_WIDTH      = 2048,
	parameter int MAX_HEIGHT     = 2048,
	parameter int MAX_LOG2_BLOCK = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    pixel_value,
	input  logic                          frame_start,
	input  logic [2:0]                    cfg_log2,
	input  logic [11:0]                   cfg_width,
	input  logic [11:0]                   cfg_height,
	output logic                          item_push,
	output logic                          item_bit,
	output logic                          item_first,
	output logic                          item_last,
	output logic [$clog2(MAX_WIDTH)-1:0]  item_bc,
	output logic [BLOCK_IDX_W-1:0]        item_br
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int W_W   = $clog2(MAX_WIDTH + 1);
	localparam int H_W   = $clog2(MAX_HEIGHT + 1);
	localparam int LG_W  = $clog2(MAX_LOG2_BLOCK + 1);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [LG_W-1:0]  lg;
	logic [31:0]      w32;
	logic [31:0]      h32;
	logic [W_W-1:0]   w;
	logic [H_W-1:0]   h;
	logic [COL_W-1:0] col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [COL_W-1:0] bc;
	logic [ROW_W-1:0] br;
	logic [31:0]      br32;
	logic [COL_W-1:0] col_mask;
	logic [ROW_W-1:0] row_mask;
	logic             in_block;
	logic [W_W:0]     col_inc;
	logic [H_W:0]     row_inc;
	logic             col_wrap;
	logic             row_wrap;

	// saturate the exponent and frame sizes; a zero frame size counts as one
	always_comb begin
		lg  = (32'(cfg_log2) > 32'(MAX_LOG2_BLOCK)) ? LG_W'(MAX_LOG2_BLOCK)
		                                            : LG_W'(cfg_log2);
		w32 = (cfg_width == '0) ? 32'd1 :
		      (32'(cfg_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(cfg_width);
		h32 = (cfg_height == '0) ? 32'd1 :
		      (32'(cfg_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(cfg_height);
		w   = w32[W_W-1:0];
		h   = h32[H_W-1:0];
	end

	// block coordinates and position inside the block
	always_comb begin
		col_cur  = frame_start ? '0 : col_q;
		row_cur  = frame_start ? '0 : row_q;
		bc       = col_cur >> lg;
		br       = row_cur >> lg;
		br32     = 32'(br);
		col_mask = COL_W'((32'd1 << lg) - 32'd1);
		row_mask = ROW_W'((32'd1 << lg) - 32'd1);
		in_block = (W_W'(bc) < (w >> lg)) && (H_W'(br) < (h >> lg));
	end

	assign item_push  = accept && in_block;
	assign item_bit   = |(pixel_value & PIXEL_SET_MASK);
	assign item_first = ((col_cur & col_mask) == '0) && ((row_cur & row_mask) == '0);
	assign item_last  = ((col_cur & col_mask) == col_mask)
	                 && ((row_cur & row_mask) == row_mask);
	assign item_bc    = bc;
	assign item_br    = br32[BLOCK_IDX_W-1:0];

	// next raster position
	always_comb begin
		col_inc  = (W_W+1)'(col_cur) + (W_W+1)'(1);
		row_inc  = (H_W+1)'(row_cur) + (H_W+1)'(1);
		col_wrap = col_inc >= (W_W+1)'(w);
		row_wrap = row_inc >= (H_W+1)'(h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_cur;
			end
		end
	end

endmodule

[hw/rtl/dbin_back.sv]
// Back end: per-block-column counter read-modify-write and result grading.
`timescale 1ns / 1ps
`include "block_density_binarizer_unit_macros.svh"

module dbin_back import dbin_pkg::*; #(
	parameter int MAX_WIDTH      = 2048,
	parameter int MAX_LOG2_BLOCK = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cq_valid,
	input  logic                           cq_bit,
	input  logic                           cq_first,
	input  logic                           cq_last,
	input  logic [$clog2(MAX_WIDTH)-1:0]   cq_bc,
	input  logic [BLOCK_IDX_W-1:0]         cq_br,
	input  logic [10:0]                    threshold,
	input  logic [$clog2(RQ_DEPTH+1)-1:0]  rq_level,
	output logic                           cq_pop,
	output logic                           rq_push,
	output dbin_result_t                   rq_item
);

	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int CNT_W  = 2 * MAX_LOG2_BLOCK + 1;
	localparam int LVL_W  = $clog2(RQ_DEPTH + 1);

	logic                   valid_s1;
	logic                   bit_s1;
	logic                   first_s1;
	logic                   last_s1;
	logic [ADDR_W-1:0]      bc_s1;
	logic [BLOCK_IDX_W-1:0] br_s1;

	logic                   valid_s2;
	logic [ADDR_W-1:0]      bc_s2;
	logic [CNT_W-1:0]       cnt_s2;

	logic [CNT_W-1:0]       rdata;
	logic [CNT_W-1:0]       prior;
	logic [CNT_W-1:0]       cnt;
	logic [31:0]            bc32;
	logic [31:0]            cnt32;

	// take an item only if the result queue has room for everything in flight
	assign cq_pop = cq_valid
	             && ((LVL_W+1)'(rq_level) + (LVL_W+1)'(valid_s1) < (LVL_W+1)'(RQ_DEPTH));

	// stage 1: item waits for the counter read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cq_pop;
		end
	end

	always_ff @(posedge clk) begin
		bit_s1   <= cq_bit;
		first_s1 <= cq_first;
		last_s1  <= cq_last;
		bc_s1    <= cq_bc;
		br_s1    <= cq_br;
	end

	// one counter per block column
	dbin_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_WIDTH)
	) u_counts (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(bc_s1),
		.wdata(cnt),
		.raddr(cq_bc),
		.rdata(rdata)
	);

	// forward the write that collided with this item's read
	always_comb begin
		prior = (valid_s2 && (bc_s2 == bc_s1)) ? cnt_s2 : rdata;
		cnt   = first_s1 ? CNT_W'(bit_s1) : prior + CNT_W'(bit_s1);
		bc32  = 32'(bc_s1);
		cnt32 = 32'(cnt);
	end

	// stage 2: remembers the last write for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		bc_s2  <= bc_s1;
		cnt_s2 <= cnt;
	end

	// a result on the bottom-right pixel of a block
	always_comb begin
		rq_push             = valid_s1 && last_s1;
		rq_item.block_row   = br_s1;
		rq_item.block_col   = bc32[BLOCK_IDX_W-1:0];
		rq_item.block_color = (cnt32 > 32'(threshold)) ? COLOR_SET : COLOR_CLEAR;
		rq_item.set_count   = cnt32[COUNT_OUT_W-1:0];
	end

	`DBIN_ASSERT(a_pop_nonempty, clk, arst_n, cq_pop, cq_valid, "pop of empty classify queue")
	`DBIN_ASSERT(a_rq_room, clk, arst_n, rq_push, rq_level < LVL_W'(RQ_DEPTH), "result queue overflow")
	`DBIN_ASSERT_NEXT(a_pop_to_s1, clk, arst_n, cq_pop, valid_s1, "popped item lost before stage 1")

endmodule

[hw/rtl/block_density_binarizer_unit.sv]
// A pixel that completes a block passes the classify queue, stage 1 and the result queue.
// Throughput: one pixel per cycle while full is low (one counter read-modify-write per pixel).
// Counter reads forward the write of the previous cycle, so equal columns back to back are fine.
// Reset: positions clear, config returns to reset values, both queues empty.
// The counter RAM is not cleared; each block counter is loaded on its top-left pixel.
`timescale 1ns / 1ps

module block_density_binarizer_unit import dbin_pkg::*; #(
	parameter int MAX_WIDTH      = 2048,
	parameter int MAX_HEIGHT     = 2048,
	parameter int MAX_LOG2_BLOCK = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             pixel_value,
	input  logic                   frame_start,
	output logic                   empty,
	input  logic                   pop,
	output logic [BLOCK_IDX_W-1:0] block_row,
	output logic [BLOCK_IDX_W-1:0] block_col,
	output logic [COLOR_W-1:0]     block_color,
	output logic [COUNT_OUT_W-1:0] set_count,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [11:0]            cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CQ_W  = 3 + BLOCK_IDX_W + COL_W;

	logic [2:0]  log2_q;
	logic [10:0] threshold_q;
	logic [11:0] width_q;
	logic [11:0] height_q;

	logic                   accept;
	logic                   f_push;
	logic                   f_bit;
	logic                   f_first;
	logic                   f_last;
	logic [COL_W-1:0]       f_bc;
	logic [BLOCK_IDX_W-1:0] f_br;

	logic [CQ_W-1:0]        cq_wdata;
	logic [CQ_W-1:0]        cq_rdata;
	logic                   cq_empty;
	logic                   cq_pop;
	logic [$clog2(CQ_DEPTH+1)-1:0] cq_level;

	logic                   rq_push;
	dbin_result_t           rq_item;
	dbin_result_t           rq_head;
	logic                   rq_full;
	logic [$clog2(RQ_DEPTH+1)-1:0] rq_level;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q      <= RST_LOG2_BLOCK;
			threshold_q <= RST_THRESHOLD;
			width_q     <= RST_WIDTH;
			height_q    <= RST_HEIGHT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOG2_BLOCK: log2_q      <= cfg_data[2:0];
				REG_THRESHOLD:  threshold_q <= cfg_data[10:0];
				REG_WIDTH:      width_q     <= cfg_data;
				REG_HEIGHT:     height_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front end
	assign accept = push && !full;

	dbin_front #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.MAX_LOG2_BLOCK(MAX_LOG2_BLOCK)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.pixel_value(pixel_value),
		.frame_start(frame_start),
		.cfg_log2   (log2_q),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.item_push  (f_push),
		.item_bit   (f_bit),
		.item_first (f_first),
		.item_last  (f_last),
		.item_bc    (f_bc),
		.item_br    (f_br)
	);

	// queue of classified pixels between front and back
	assign cq_wdata = {f_bit, f_first, f_last, f_br, f_bc};

	dbin_fifo #(
		.WIDTH(CQ_W),
		.DEPTH(CQ_DEPTH)
	) u_cq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata (cq_wdata),
		.pop   (cq_pop),
		.rdata (cq_rdata),
		.empty (cq_empty),
		.full  (full),
		.level (cq_level)
	);

	// back end
	dbin_back #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_LOG2_BLOCK(MAX_LOG2_BLOCK)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (!cq_empty && (cq_level != '0)),
		.cq_bit   (cq_rdata[CQ_W-1]),
		.cq_first (cq_rdata[CQ_W-2]),
		.cq_last  (cq_rdata[CQ_W-3]),
		.cq_bc    (cq_rdata[COL_W-1:0]),
		.cq_br    (cq_rdata[COL_W +: BLOCK_IDX_W]),
		.threshold(threshold_q),
		.rq_level (rq_level),
		.cq_pop   (cq_pop),
		.rq_push  (rq_push),
		.rq_item  (rq_item)
	);

	// result queue toward the consumer
	dbin_fifo #(
		.WIDTH($bits(dbin_result_t)),
		.DEPTH(RQ_DEPTH)
	) u_rq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push && !rq_full),
		.wdata (rq_item),
		.pop   (pop && !empty),
		.rdata (rq_head),
		.empty (empty),
		.full  (rq_full),
		.level (rq_level)
	);

	assign block_row   = rq_head.block_row;
	assign block_col   = rq_head.block_col;
	assign block_color = rq_head.block_color;
	assign set_count   = rq_head.set_count;

endmodule

[test/tb_block_density_binarizer_unit.sv]
// Self-checking testbench of the block density binarizer: stream driver, result monitor, scoreboard.
`timescale 1ns / 1ps

module tb_block_density_binarizer_unit;
	import dbin_pkg::*;

	localparam int unsigned FRAME_MAX_W = 2048;
	localparam int unsigned FRAME_MAX_H = 2048;
	localparam int unsigned LOG2_CAP    = 5;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD   = 400;

	typedef struct packed {
		logic [7:0] pix;
		logic       fs;
	} pixel_item_t;

	// receiver pop patterns
	typedef enum int {RX_FREE, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] pixel_value = 8'd0;
	logic frame_start = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [BLOCK_IDX_W-1:0] block_row;
	logic [BLOCK_IDX_W-1:0] block_col;
	logic [COLOR_W-1:0] block_color;
	logic [COUNT_OUT_W-1:0] set_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_LOG2_BLOCK;
	logic [11:0] cfg_data = 12'd0;

	// shadow of the configuration registers
	logic [2:0]  lg_reg     = RST_LOG2_BLOCK;
	logic [10:0] thr_reg    = RST_THRESHOLD;
	logic [11:0] width_reg  = RST_WIDTH;
	logic [11:0] height_reg = RST_HEIGHT;

	// shadow of the scan position and per-column block counters
	logic [10:0] col_pos = '0;
	logic [10:0] row_pos = '0;
	logic [10:0] col_count [FRAME_MAX_W];

	pixel_item_t  pixel_q [$];
	dbin_result_t pending_blocks [$];

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	pixel_item_t next_px;

	rx_mode_t rx_mode = RX_FREE;
	int unsigned rx_cycle = 0;
	int unsigned hold_left = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	dbin_result_t want_blk;

	int unsigned mismatches = 0;

	block_density_binarizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel_value(pixel_value),
		.frame_start(frame_start),
		.empty(empty),
		.pop(pop),
		.block_row(block_row),
		.block_col(block_col),
		.block_color(block_color),
		.set_count(set_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// zero counts as one, large values saturate
	function automatic int unsigned frame_limit(input logic [11:0] v, input int unsigned top);
		if (v == 12'd0)
			return 1;
		return (v > top) ? top : int'(v);
	endfunction

	// advance the block grid by one pixel and queue the block it completes, if any
	task automatic grade_pixel(input logic [7:0] px, input logic fs);
		int unsigned lg, w, h, msk, col, row, bc, br, cnt, hit;
		dbin_result_t blk;
		lg = (lg_reg > LOG2_CAP) ? LOG2_CAP : lg_reg;
		w = frame_limit(width_reg, FRAME_MAX_W);
		h = frame_limit(height_reg, FRAME_MAX_H);
		msk = (1 << lg) - 1;
		hit = ((px & PIXEL_SET_MASK) != 0) ? 1 : 0;
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
		end
		col = col_pos;
		row = row_pos;
		bc = col >> lg;
		br = row >> lg;
		// only whole blocks are graded
		if (bc < (w >> lg) && br < (h >> lg)) begin
			if ((col & msk) == 0 && (row & msk) == 0)
				cnt = hit;
			else
				cnt = col_count[bc] + hit;
			col_count[bc] = 11'(cnt);
			if ((col & msk) == msk && (row & msk) == msk) begin
				blk.block_row   = 11'(br);
				blk.block_col   = 11'(bc);
				blk.block_color = (cnt > thr_reg) ? COLOR_SET : COLOR_CLEAR;
				blk.set_count   = 11'(cnt);
				pending_blocks.push_back(blk);
			end
		end
		// raster advance with wrap
		if (col + 1 >= w) begin
			col_pos = '0;
			row_pos = (row + 1 >= h) ? 11'd0 : 11'(row + 1);
		end else begin
			col_pos = 11'(col + 1);
		end
	endtask

	function automatic bit stream_busy();
		return pixel_q.size() != 0 || push || pending_blocks.size() != 0;
	endfunction

	// wait for every item and result to clear, then let the pipeline settle
	task automatic drain();
		int unsigned waited;
		waited = 0;
		while (stream_busy() && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LOG2_BLOCK: lg_reg = val[2:0];
			REG_THRESHOLD:  thr_reg = val[10:0];
			REG_WIDTH:      width_reg = val;
			REG_HEIGHT:     height_reg = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_geometry(input int unsigned lg, input int unsigned thr,
			input int unsigned w, input int unsigned h);
		drain();
		write_reg(REG_LOG2_BLOCK, 12'(lg));
		write_reg(REG_THRESHOLD, 12'(thr));
		write_reg(REG_WIDTH, 12'(w));
		write_reg(REG_HEIGHT, 12'(h));
	endtask

	task automatic queue_pixel(input logic [7:0] pix, input logic fs);
		pixel_item_t it;
		it.pix = pix;
		it.fs = fs;
		pixel_q.push_back(it);
	endtask

	// random mask pixels, mostly restarting at frame boundaries; restart_odds = 0 disables mid-frame restarts
	task automatic queue_frames(input int unsigned n, input int unsigned ones_pct,
			input logic lead_start, input int unsigned restart_odds);
		int unsigned area;
		logic fs;
		logic [7:0] pix;
		area = frame_limit(width_reg, FRAME_MAX_W) * frame_limit(height_reg, FRAME_MAX_H);
		for (int unsigned k = 0; k < n; k++) begin
			pix = 8'($urandom_range(0, 255));
			pix[0] = ($urandom_range(0, 99) < ones_pct);
			if (k == 0)
				fs = lead_start;
			else if (k % area == 0)
				fs = ($urandom_range(0, 9) != 0);
			else
				fs = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
			queue_pixel(pix, fs);
		end
	endtask

	// driver: bursts of items with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				grade_pixel(pixel_value, frame_start);
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					next_px = pixel_q.pop_front();
					push <= 1'b1;
					pixel_value <= next_px.pix;
					frame_start <= next_px.fs;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: check each popped block, then pick the next pop
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_blocks.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected block row %0d col %0d color %0d count %0d",
						$time, block_row, block_col, block_color, set_count);
				end else begin
					want_blk = pending_blocks.pop_front();
					if (block_row !== want_blk.block_row) begin
						mismatches++;
						$display("%0t: block_row expected %0d actual %0d",
							$time, want_blk.block_row, block_row);
					end
					if (block_col !== want_blk.block_col) begin
						mismatches++;
						$display("%0t: block_col expected %0d actual %0d",
							$time, want_blk.block_col, block_col);
					end
					if (block_color !== want_blk.block_color) begin
						mismatches++;
						$display("%0t: block_color expected %0d actual %0d",
							$time, want_blk.block_color, block_color);
					end
					if (set_count !== want_blk.set_count) begin
						mismatches++;
						$display("%0t: set_count expected %0d actual %0d",
							$time, want_blk.set_count, set_count);
					end
				end
			end
			// stall pattern, with one long hold-off on request
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:   pop <= 1'b1;
					RX_COIN:   pop <= 1'($urandom_range(0, 1));
					RX_EVERY4: pop <= (rx_cycle % 4 == 0);
					default:   pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// stimulus sequence
	initial begin
		int unsigned lg, lge, thr, wd, ht, random_items;
		logic [15:0] quad_pattern;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero frame size counts as a single 1x1 block
		set_geometry(0, 0, 0, 0);
		queue_pixel(8'h01, 1'b1);
		queue_pixel(8'hFE, 1'b0);
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'h00, 1'b0);

		// 2x2 blocks on a 4x4 frame with counts 0, 1, 2 and 4 around threshold 1
		set_geometry(1, 1, 4, 4);
		quad_pattern = 16'b1110_1101_0000_0100;
		for (int k = 0; k < 16; k++)
			queue_pixel({7'($urandom), quad_pattern[k]}, k == 0);

		// partial blocks at the right and bottom edge are dropped
		set_geometry(1, $urandom_range(0, 4), 5, 3);
		queue_frames(15, 50, 1'b1, 0);

		// oversized exponent saturates to 32x32; full block count at the threshold edge
		set_geometry(7, $urandom_range(1023, 1024), 32, 32);
		queue_frames(1024, 100, 1'b1, 0);

		// oversized row width, with a long receiver hold-off so the results back up
		set_geometry(0, 0, 4095, 1);
		queue_frames(80, 50, 1'b1, 0);
		hold_req = 1'b1;

		// tallest column, entered with the column position beyond the new width
		set_geometry(0, 0, 1, 4095);
		queue_frames(40, 50, 1'b0, 0);

		// random geometries
		random_items = 0;
		while (random_items < 120) begin
			lg = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			lge = (lg > LOG2_CAP) ? LOG2_CAP : lg;
			case ($urandom_range(0, 9))
				0:       thr = 0;
				1:       thr = 2047;
				default: thr = $urandom_range(0, 1 << (2 * lge));
			endcase
			case ($urandom_range(0, 9))
				0:       wd = 0;
				1:       wd = $urandom_range(2040, 4095);
				default: wd = $urandom_range(1, 24);
			endcase
			case ($urandom_range(0, 9))
				0:       ht = 0;
				1:       ht = $urandom_range(2040, 4095);
				default: ht = $urandom_range(1, 24);
			endcase
			set_geometry(lg, thr, wd, ht);
			queue_frames(20, $urandom_range(0, 100), 1'b1, 40);
			random_items += 20;
		end

		drain();
		if (pending_blocks.size() != 0) begin
			mismatches += pending_blocks.size();
			$display("%0t: %0d expected blocks never arrived, next row %0d col %0d",
				$time, pending_blocks.size(), pending_blocks[0].block_row,
				pending_blocks[0].block_col);
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
